FILE: design/lbms_pkg.sv
package lbms_pkg;

	localparam int unsigned HOLD_W  = 12;
	localparam int unsigned PHASE_W = 10;
	localparam int unsigned COUNT_W = 12;
	localparam int unsigned STEP_W  = 5;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CFG_W   = 12;

	localparam logic [HOLD_W-1:0]  LONG_PRESS_RESET = 12'd3000;
	localparam logic [PHASE_W-1:0] PHASE_RESET      = 10'd1000;

	// Configuration register indexes.
	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_PHASE      = 1'b1;

	// Mode codes.
	localparam logic [MODE_W-1:0] MODE_SHORT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LONG    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPECIAL = 2'd2;

	// Step counter wrap points and LED source boundaries.
	localparam logic [STEP_W-1:0] STEP_WRAP_SHORT = 5'd14;
	localparam logic [STEP_W-1:0] STEP_WRAP_LONG  = 5'd26;
	localparam logic [STEP_W-1:0] SHORT_A_LAST    = 5'd4;
	localparam logic [STEP_W-1:0] SHORT_B_LAST    = 5'd12;
	localparam logic [STEP_W-1:0] LONG_A_LAST     = 5'd8;
	localparam logic [STEP_W-1:0] LONG_B_END      = 5'd24;

	typedef struct packed {
		logic flag_a;
		logic flag_b;
		logic a_toggle;
	} phase_t;

	typedef struct packed {
		logic              pattern_led;
		logic              hold_led;
		logic              press_led;
		logic [MODE_W-1:0] current_mode;
	} result_t;

endpackage

FILE: design/lbms_phase.sv
module lbms_phase import lbms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic [PHASE_W-1:0] phase_ticks,
	output phase_t             phase
);

	logic [COUNT_W-1:0] count_q;
	logic               flag_a_q;
	logic               flag_b_q;

	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] p1, p2, p3, p4;
	logic [COUNT_W-1:0] count_n;
	logic               flag_a_n;
	logic               flag_b_n;

	always_comb begin
		count_inc = count_q + 12'd1;
		p1 = {{(COUNT_W-PHASE_W){1'b0}}, phase_ticks};
		p2 = p1 << 1;
		p3 = p2 + p1;
		p4 = p1 << 2;
		count_n  = count_inc;
		flag_a_n = flag_a_q;
		flag_b_n = flag_b_q;
		if (count_inc >= p4) begin
			flag_a_n = 1'b0;
			flag_b_n = 1'b0;
			count_n  = '0;
		end else if (count_inc >= p3) begin
			flag_a_n = 1'b1;
			flag_b_n = 1'b1;
		end else if (count_inc >= p2) begin
			flag_a_n = 1'b0;
			flag_b_n = 1'b1;
		end else if (count_inc >= p1) begin
			flag_a_n = 1'b1;
		end
	end

	// The previous level of flag A is always the stored flag A itself.
	assign phase.flag_a   = flag_a_n;
	assign phase.flag_b   = flag_b_n;
	assign phase.a_toggle = flag_a_n ^ flag_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			flag_a_q <= 1'b0;
			flag_b_q <= 1'b0;
		end else if (tick) begin
			count_q  <= count_n;
			flag_a_q <= flag_a_n;
			flag_b_q <= flag_b_n;
		end
	end

endmodule

FILE: design/lbms_mode.sv
module lbms_mode import lbms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              button_held,
	input  logic [HOLD_W-1:0] long_press_ticks,
	input  phase_t            phase,
	output result_t           result
);

	logic              released_q;
	logic              button_before_q;
	logic [HOLD_W-1:0] hold_q;
	logic [MODE_W-1:0] mode_q;
	logic [STEP_W-1:0] step_q;
	logic              led_q;

	logic              released_n;
	logic [STEP_W-1:0] step_inc;
	logic [STEP_W-1:0] step_n;
	logic              held_long;
	logic [MODE_W-1:0] mode_1, mode_2, mode_n;
	logic [HOLD_W:0]   hold_inc;
	logic [HOLD_W-1:0] hold_n;
	logic              hold_led;
	logic              led_n;

	always_comb begin
		if (button_held) begin
			released_n = 1'b0;
		end else begin
			released_n = button_before_q | released_q;
		end

		step_inc = phase.a_toggle ? step_q + 5'd1 : step_q;
		step_n   = step_inc;
		if (mode_q == MODE_SHORT) begin
			if (step_inc >= STEP_WRAP_SHORT) begin
				step_n = '0;
			end
		end else if (step_inc >= STEP_WRAP_LONG) begin
			step_n = '0;
		end

		// Mode rules look at the hold count from before this transaction.
		held_long = hold_q >= long_press_ticks;
		mode_1 = (released_n && held_long) ? MODE_LONG : mode_q;
		mode_2 = (button_held && !held_long && mode_1 == MODE_LONG) ? MODE_SPECIAL : mode_1;
		mode_n = mode_2;
		if (released_n && !held_long && mode_2 == MODE_SPECIAL) begin
			mode_n = MODE_SHORT;
			step_n = '0;
		end
		if (mode_q == MODE_SHORT && mode_n == MODE_LONG) begin
			step_n = '0;
		end

		hold_inc = {1'b0, hold_q} + 13'd1;
		if (!button_held) begin
			hold_n   = '0;
			hold_led = 1'b0;
		end else if (hold_inc >= {1'b0, long_press_ticks}) begin
			hold_n   = long_press_ticks;
			hold_led = 1'b1;
		end else begin
			hold_n   = hold_inc[HOLD_W-1:0];
			hold_led = 1'b0;
		end

		led_n = led_q;
		case (mode_n)
			MODE_LONG, MODE_SPECIAL: begin
				if (step_n <= LONG_A_LAST) begin
					led_n = phase.flag_a;
				end else if (step_n < LONG_B_END) begin
					led_n = phase.flag_b;
				end
			end
			MODE_SHORT: begin
				if (step_n <= SHORT_A_LAST) begin
					led_n = phase.flag_a;
				end else if (step_n <= SHORT_B_LAST) begin
					led_n = phase.flag_b;
				end
			end
			default: led_n = led_q;
		endcase
	end

	assign result.pattern_led  = led_n;
	assign result.hold_led     = hold_led;
	assign result.press_led    = button_held;
	assign result.current_mode = mode_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q      <= 1'b0;
			button_before_q <= 1'b0;
			hold_q          <= '0;
			mode_q          <= MODE_SHORT;
			step_q          <= '0;
			led_q           <= 1'b0;
		end else if (tick) begin
			released_q      <= released_n;
			button_before_q <= button_held;
			hold_q          <= hold_n;
			mode_q          <= mode_n;
			step_q          <= step_n;
			led_q           <= led_n;
		end
	end

endmodule

FILE: design/led_blink_mode_sequencer_core.sv
// LED blink mode sequencer.
// Input stream s_*: one transaction per tick, s_tdata[0] is the debounced button level.
// Output stream m_*: one transaction per input transaction, in order, carrying the
// pattern LED, hold LED, press LED and the current mode (0 short, 1 long, 2 special).
// Configuration: cfg_we writes cfg_data into register cfg_index in the same edge;
// index 0 is the long press length in ticks, index 1 the ticks per blink phase.
// Write configuration only while no transaction is in flight.
// A transaction moves from the input register through the tick update into the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register. The input register
// still takes one transaction if it is empty, and s_tready stays low while both are full.
// Reset clears all counters and flags, selects short mode, empties both registers
// and loads the default settings of 3000 and 1000 ticks.
module led_blink_mode_sequencer_core import lbms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [0] button_held, [7:1] zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [0] pattern_led, [1] hold_led, [2] press_led,
	                                    // [4:3] current_mode, [7:5] zero
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [HOLD_W-1:0]  long_press_q;
	logic [PHASE_W-1:0] phase_ticks_q;

	logic    valid_s1;
	logic    button_s1;
	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	phase_t  phase;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= LONG_PRESS_RESET;
			phase_ticks_q <= PHASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS: long_press_q  <= cfg_data[HOLD_W-1:0];
				REG_PHASE:      phase_ticks_q <= cfg_data[PHASE_W-1:0];
				default:        long_press_q  <= long_press_q;
			endcase
		end
	end

	// The tick in the input register is processed once the output register can take it.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			button_s1 <= s_tdata[0];
		end
	end

	lbms_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (advance),
		.phase_ticks (phase_ticks_q),
		.phase       (phase)
	);

	lbms_mode u_mode (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (advance),
		.button_held      (button_s1),
		.long_press_ticks (long_press_q),
		.phase            (phase),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.current_mode, out_q.press_led, out_q.hold_led,
		out_q.pattern_led};

`ifndef NO_ASSERTIONS
	a_hold_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2] || !m_tdata[1]))
		else $error("hold LED lit without the button held");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed tick did not reach the output register");

	a_ready_when_output_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_mode_code_used: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (result.current_mode == MODE_SHORT || result.current_mode == MODE_LONG
			|| result.current_mode == MODE_SPECIAL))
		else $error("mode update produced the unused code");
`endif

endmodule
